[hdl/spdds_pkg.sv]
// Shared constants, register codes and the sine magnitude function
// for the DDS sine generator. No dependencies.
package spdds_pkg;

  localparam int ADC_W     = 10;
  localparam int DELTA_W   = 4;
  localparam int STEP_W    = 32;
  localparam int DUTY_W    = 8;
  localparam int IDX_W     = 8;
  localparam int PROD_W    = ADC_W + STEP_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = STEP_W;

  localparam int SAMPLES_PER_HALF_DEF = 64;
  localparam int SINE_INDEX_BITS_DEF  = 10;
  localparam int PHASE_BITS_DEF       = 32;

  localparam logic [DELTA_W-1:0] DELTA_RST = DELTA_W'(2);
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(32916);

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HYST = 1'b0,
    CFG_STEP = 1'b1
  } cfg_reg_e;

  // Quarter-wave magnitude for a reflected angle h, floor(255 * sin), Q30 Taylor form.
  function automatic logic [DUTY_W-1:0] sine_mag_f(input int unsigned h,
                                                   input int unsigned sib);
    longint unsigned x;
    longint unsigned y;
    longint unsigned t;
    longint unsigned s;
    longint unsigned m;
    x = (64'(h) * HALF_PI_Q30) >> (sib - 2);
    y = (x * x) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - ((y * t) >> 30) / 64'd110;
    t = Q30_ONE - ((y * t) >> 30) / 64'd72;
    t = Q30_ONE - ((y * t) >> 30) / 64'd42;
    t = Q30_ONE - ((y * t) >> 30) / 64'd20;
    t = Q30_ONE - ((y * t) >> 30) / 64'd6;
    s = (x * t) >> 30;
    m = (s * 64'd255 + (64'd1 << 20)) >> 30;
    if (m > 64'd255) begin
      m = 64'd255;
    end
    return m[DUTY_W-1:0];
  endfunction

endpackage

[hdl/spdds_level.sv]
// Input register, hysteresis on the held level and the phase increment product.
// Depends on spdds_pkg.
module spdds_level (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [spdds_pkg::DELTA_W-1:0]  delta_i,
  input  logic [spdds_pkg::STEP_W-1:0]   step_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [spdds_pkg::ADC_W-1:0]    adc_sample_i,
  output logic                           prod_valid_o,
  input  logic                           prod_ready_i,
  output logic [spdds_pkg::PROD_W-1:0]   prod_o
);
  import spdds_pkg::*;

  logic [ADC_W-1:0]  adc_q;
  logic              adc_vld_q;
  logic [ADC_W-1:0]  held_q, held_d;
  logic [ADC_W-1:0]  diff;
  logic [PROD_W-1:0] prod_q;
  logic              prod_vld_q;
  logic              prod_rdy;

  assign prod_rdy   = !prod_vld_q || prod_ready_i;
  assign in_ready_o = !adc_vld_q || prod_rdy;

  always_comb begin
    diff   = (adc_q >= held_q) ? (adc_q - held_q) : (held_q - adc_q);
    held_d = (diff >= ADC_W'(delta_i)) ? adc_q : held_q;
    if (held_d == '0) begin
      held_d = ADC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      held_q     <= '0;
    end else begin
      if (in_ready_o) begin
        adc_vld_q <= in_valid_i;
      end
      if (prod_rdy) begin
        prod_vld_q <= adc_vld_q;
        if (adc_vld_q) begin
          held_q <= held_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      adc_q <= adc_sample_i;
    end
    if (prod_rdy && adc_vld_q) begin
      prod_q <= PROD_W'(held_d) * PROD_W'(step_i);
    end
  end

  assign prod_valid_o = prod_vld_q;
  assign prod_o       = prod_q;

endmodule

[hdl/spdds_phase.sv]
// Phase accumulator, wrap detection and sample slot tracking.
// Depends on spdds_pkg.
module spdds_phase #(
  parameter int SAMPLES_PER_HALF = spdds_pkg::SAMPLES_PER_HALF_DEF,
  parameter int SINE_INDEX_BITS  = spdds_pkg::SINE_INDEX_BITS_DEF,
  parameter int PHASE_BITS       = spdds_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          prod_valid_i,
  output logic                          prod_ready_o,
  input  logic [spdds_pkg::PROD_W-1:0]  prod_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [SINE_INDEX_BITS-1:0]    top_o,
  output logic                          taken_o
);
  import spdds_pkg::*;

  localparam int SUMW = ((PHASE_BITS > PROD_W) ? PHASE_BITS : PROD_W) + 1;
  localparam int TW   = PHASE_BITS + IDX_W;
  // One sample slot: period / (2 * samples per half-wave), rounded down.
  localparam logic [TW-1:0] SLOT =
    TW'((64'd1 << PHASE_BITS) / (64'd2 * 64'(SAMPLES_PER_HALF)));

  logic [PHASE_BITS-1:0]      phase_q, phase_n;
  logic [IDX_W-1:0]           idx_q, idx_e, idx_d;
  logic [TW-1:0]              thr_q, thr_e, thr_d;
  logic [SUMW-1:0]            sum;
  logic                       wrap, take, mv;
  logic                       vld_q, taken_q;
  logic [SINE_INDEX_BITS-1:0] top_q;

  assign prod_ready_o = !vld_q || ready_i;
  assign mv           = prod_valid_i && prod_ready_o;

  always_comb begin
    sum     = SUMW'(phase_q) + SUMW'(prod_i);
    wrap    = |sum[SUMW-1:PHASE_BITS];
    phase_n = sum[PHASE_BITS-1:0];
    // a wrap restarts the index, so the slot threshold drops to zero
    idx_e   = wrap ? '0 : idx_q;
    thr_e   = wrap ? '0 : thr_q;
    take    = TW'(phase_n) >= thr_e;
    idx_d   = idx_e;
    thr_d   = thr_e;
    if (take) begin
      idx_d = idx_e + IDX_W'(1);
      thr_d = (idx_e == '1) ? '0 : thr_e + SLOT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      idx_q   <= IDX_W'(1);
      thr_q   <= SLOT;
      vld_q   <= 1'b0;
      taken_q <= 1'b0;
    end else begin
      if (prod_ready_o) begin
        vld_q   <= prod_valid_i;
        taken_q <= prod_valid_i && take;
      end
      if (mv) begin
        phase_q <= phase_n;
        idx_q   <= idx_d;
        thr_q   <= thr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv) begin
      top_q <= phase_n[PHASE_BITS-1 -: SINE_INDEX_BITS];
    end
  end

  assign valid_o = vld_q;
  assign top_o   = top_q;
  assign taken_o = taken_q;

  a_thr_tracks_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_q == TW'(idx_q) * SLOT)
    else $error("slot threshold out of step with sample index");

  a_wrap_takes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv && wrap) |=> taken_q)
    else $error("phase wrap did not take a sample");

  a_taken_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q |-> vld_q)
    else $error("sample flag on an empty stage");

endmodule

[hdl/spdds_shaper.sv]
// Quarter-wave sine table lookup, sign steering and the held duty registers.
// Depends on spdds_pkg (sine_mag_f fills the table at elaboration).
module spdds_shaper #(
  parameter int SINE_INDEX_BITS = spdds_pkg::SINE_INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [SINE_INDEX_BITS-1:0]    top_i,
  input  logic                          taken_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [spdds_pkg::DUTY_W-1:0]  duty_positive_o,
  output logic [spdds_pkg::DUTY_W-1:0]  duty_negative_o,
  output logic                          sample_taken_o
);
  import spdds_pkg::*;

  localparam int HW      = SINE_INDEX_BITS - 1;
  localparam int QUARTER = 1 << (SINE_INDEX_BITS - 2);

  logic [DUTY_W-1:0] lut [QUARTER+1];
  logic [HW-1:0]     h_raw, h_ref;
  logic [DUTY_W-1:0] mag_q;
  logic              neg_q, tkn_q, vld_q;
  logic              ready_b;
  logic [DUTY_W-1:0] pos_q, negd_q;
  logic              out_tkn_q, out_vld_q;

  for (genvar g = 0; g <= QUARTER; g++) begin : g_lut
    localparam logic [DUTY_W-1:0] MAG = sine_mag_f(g, SINE_INDEX_BITS);
    assign lut[g] = MAG;
  end

  // fold the half-wave angle into the first quarter
  always_comb begin
    h_raw = top_i[HW-1:0];
    h_ref = (h_raw > HW'(QUARTER)) ? (~h_raw + HW'(1)) : h_raw;
  end

  assign ready_b = !out_vld_q || out_ready_i;
  assign ready_o = !vld_q || ready_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      out_vld_q <= 1'b0;
      out_tkn_q <= 1'b0;
      pos_q     <= '0;
      negd_q    <= '0;
    end else begin
      if (ready_o) begin
        vld_q <= valid_i;
      end
      if (ready_b) begin
        out_vld_q <= vld_q;
        if (vld_q) begin
          out_tkn_q <= tkn_q;
          if (tkn_q) begin
            pos_q  <= neg_q ? '0 : mag_q;
            negd_q <= neg_q ? mag_q : '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mag_q <= lut[h_ref];
      neg_q <= top_i[SINE_INDEX_BITS-1];
      tkn_q <= taken_i;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign duty_positive_o = pos_q;
  assign duty_negative_o = negd_q;
  assign sample_taken_o  = out_tkn_q;

endmodule

[hdl/sine_pwm_dds_generator_top.sv]
// Top level of the DDS sine generator for two half-wave PWM duties.
// Depends on spdds_pkg, spdds_level, spdds_phase and spdds_shaper.
//
//  channel  | direction | handshake                    | word
//  ---------+-----------+------------------------------+------------------------------------
//  in       | in        | in_valid_i / in_ready_o      | adc_sample_i
//  out      | out       | out_valid_o / out_ready_i    | duty_positive_o, duty_negative_o,
//           |           |                              | sample_taken_o
//  cfg      | in        | cfg_we_i (no wait)           | cfg_idx_i, cfg_wdata_i
//
// Throughput is one word per clock while out_ready_i holds; a word passes the input,
// product, phase, table and duty registers. The rate is set by the phase accumulator
// loop: one add of the registered increment plus one compare against the slot threshold
// per cycle. Reset (rst_ni low, async) zeroes level, phase and duties, sets the index
// to one and loads the register defaults. Each stage carries its own valid bit and
// moves when the stage after it is empty or moving, so bubbles close up during stalls.
module sine_pwm_dds_generator_top #(
  parameter int SAMPLES_PER_HALF = spdds_pkg::SAMPLES_PER_HALF_DEF,
  parameter int SINE_INDEX_BITS  = spdds_pkg::SINE_INDEX_BITS_DEF,
  parameter int PHASE_BITS       = spdds_pkg::PHASE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spdds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spdds_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [spdds_pkg::ADC_W-1:0]      adc_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [spdds_pkg::DUTY_W-1:0]     duty_positive_o,
  output logic [spdds_pkg::DUTY_W-1:0]     duty_negative_o,
  output logic                             sample_taken_o
);
  import spdds_pkg::*;

  logic [DELTA_W-1:0]         delta_q;
  logic [STEP_W-1:0]          step_q;
  logic                       prod_vld, prod_rdy;
  logic [PROD_W-1:0]          prod;
  logic                       ph_vld, ph_rdy, ph_taken;
  logic [SINE_INDEX_BITS-1:0] ph_top;

  // Configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= DELTA_RST;
      step_q  <= STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_HYST: delta_q <= cfg_wdata_i[DELTA_W-1:0];
        CFG_STEP: step_q  <= cfg_wdata_i[STEP_W-1:0];
        default:  ;
      endcase
    end
  end

  // Stage 1-2: input register, hysteresis, held level times step.
  spdds_level u_level (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .delta_i      (delta_q),
    .step_i       (step_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .adc_sample_i (adc_sample_i),
    .prod_valid_o (prod_vld),
    .prod_ready_i (prod_rdy),
    .prod_o       (prod)
  );

  // Stage 3: phase accumulate, wrap, slot compare.
  spdds_phase #(
    .SAMPLES_PER_HALF (SAMPLES_PER_HALF),
    .SINE_INDEX_BITS  (SINE_INDEX_BITS),
    .PHASE_BITS       (PHASE_BITS)
  ) u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_vld),
    .prod_ready_o (prod_rdy),
    .prod_i       (prod),
    .valid_o      (ph_vld),
    .ready_i      (ph_rdy),
    .top_o        (ph_top),
    .taken_o      (ph_taken)
  );

  // Stage 4-5: sine table read, then duty registers that double as output word.
  spdds_shaper #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_shaper (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (ph_vld),
    .ready_o         (ph_rdy),
    .top_i           (ph_top),
    .taken_i         (ph_taken),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .duty_positive_o (duty_positive_o),
    .duty_negative_o (duty_negative_o),
    .sample_taken_o  (sample_taken_o)
  );

endmodule
